// ===== hw/rtl/rhohm_pkg.sv =====
// Package for the insertion-ordered Robin Hood hash map.
// Holds the sizes, operation and status codes, item types and FSM states.
// No dependencies.
package rhohm_pkg;

    localparam int BUCKETS     = 256;
    localparam int ENTRY_SLOTS = 192;
    localparam int HASH_BITS   = 32;
    localparam int BKT_W       = 8;   // bucket address width
    localparam int ENT_W       = 8;   // entry number width

    localparam logic [ENT_W-1:0] ENT_EMPTY  = 8'hFF;
    localparam logic [ENT_W-1:0] ENT_SLOTS8 = 8'(ENTRY_SLOTS);
    localparam logic [8:0]       LAST_STEP  = 9'(BUCKETS - 1);

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_LOOKUP  = 3'd1;
    localparam logic [2:0] OP_REMOVE  = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_ITERATE = 3'd4;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_HIT      = 3'd2;
    localparam logic [2:0] ST_MISS     = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_ITER_END = 3'd5;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] key;
        logic [31:0] key_digest;
        logic [63:0] value;
        logic [7:0]  position;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] found_key;
        logic [63:0] found_value;
        logic [7:0]  next_position;
        logic [7:0]  live_entries;
    } t_out;

    typedef struct packed {
        logic                 hole;
        logic [HASH_BITS-1:0] hash;
        logic [63:0]          key;
        logic [63:0]          value;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic [BKT_W-1:0] rd_addr;
        logic             wr_en;
        logic [BKT_W-1:0] wr_addr;
        logic [ENT_W-1:0] wr_data;
        logic             clr;
    } t_bkt_req;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_INS_CHK, S_PRB_RD, S_PRB_BK, S_PRB_EN, S_UL_CLR, S_REM_CHK,
        S_CMP_BEGIN, S_CMP_RD, S_CMP_WR, S_CMP_CLR, S_RB_RD, S_RB_EN,
        S_IT_RD, S_IT_EN, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_FIND, M_INS, M_PLACE, M_UNLINK
    } t_mode;

endpackage

// ===== hw/rtl/rhohm_bucket_index.sv =====
// Bucket index memory of the hash map: entry numbers with one valid bit per bucket.
// A bucket that is not valid reads as empty; clearing drops all valid bits at once.
// Depends on rhohm_pkg.
module rhohm_bucket_index (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rhohm_pkg::t_bkt_req        i_req,
    output logic [rhohm_pkg::ENT_W-1:0] o_rd_data
);
    import rhohm_pkg::*;

    logic [ENT_W-1:0]   mem [BUCKETS];
    logic [BUCKETS-1:0] r_valid;
    logic [ENT_W-1:0]   r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // A read of the bucket being written returns the new value.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            if (i_req.wr_en && i_req.wr_addr == i_req.rd_addr) begin
                r_rd_data <= i_req.wr_data;
            end else if (r_valid[i_req.rd_addr]) begin
                r_rd_data <= mem[i_req.rd_addr];
            end else begin
                r_rd_data <= ENT_EMPTY;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/robin_hood_ordered_hash_map.sv =====
// Insertion-ordered hash map with a Robin Hood bucket index, top level.
// Holds the entry memory and the operation sequencer; uses rhohm_bucket_index.
// Depends on rhohm_pkg.
//
// One item is worked at a time; a new item is taken while the previous result
// waits at the output. Every probe step reads a bucket and then the entry it
// names, in states S_PRB_RD, S_PRB_BK and S_PRB_EN: a lookup probes bucket by
// bucket, an insert first passes S_INS_CHK and walks on while placing a
// displaced entry, a remove backshifts bucket by bucket with an S_UL_CLR step,
// and an iterate scans entry slots in S_IT_RD and S_IT_EN. When a remove
// leaves half or more of the used entry slots as holes, or an insert meets a
// full entry array with holes, the entries are compacted and every entry is
// placed in the bucket index again. The bucket index is empty after reset at
// once; no clearing pass is needed.
module robin_hood_ordered_hash_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rhohm_pkg::t_in    i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rhohm_pkg::t_out   o_out
);
    import rhohm_pkg::*;

    // Entry memory.
    t_entry              ent_mem [ENTRY_SLOTS];
    t_entry              r_ent_q;
    logic                ent_rd_en;
    logic [ENT_W-1:0]    ent_rd_addr;
    logic                ent_we;
    logic [ENT_W-1:0]    ent_wa;
    t_entry              ent_wd;

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (ent_rd_en) begin
            r_ent_q <= ent_mem[ent_rd_addr];
        end
    end

    t_bkt_req         bk;
    logic [ENT_W-1:0] bk_q;

    rhohm_bucket_index u_bkt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (bk),
        .o_rd_data (bk_q)
    );

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [2:0]       r_op, n_op;
    logic [63:0]      r_key, n_key;
    logic [31:0]      r_hash, n_hash;
    logic [63:0]      r_val, n_val;
    logic [7:0]       r_pos, n_pos;
    logic [BKT_W-1:0] r_b, n_b;
    logic [9:0]       r_d, n_d;
    logic [8:0]       r_n, n_n;
    logic [ENT_W-1:0] r_r, n_r;
    logic [ENT_W-1:0] r_ent, n_ent;
    logic [BKT_W-1:0] r_hole, n_hole;
    logic [ENT_W-1:0] r_ci, n_ci;
    logic [ENT_W-1:0] r_w, n_w;
    logic [ENT_W-1:0] r_used, n_used;
    logic [ENT_W-1:0] r_live, n_live;
    logic             r_rebuild, n_rebuild;
    logic             r_cret_ins, n_cret_ins;
    logic [2:0]       r_status, n_status;
    logic [63:0]      r_fk, n_fk;
    logic [63:0]      r_fv, n_fv;
    logic [7:0]       r_np, n_np;
    t_out             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_live      <= '0;
            r_rebuild   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_live      <= n_live;
            r_rebuild   <= n_rebuild;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_op       <= n_op;
        r_key      <= n_key;
        r_hash     <= n_hash;
        r_val      <= n_val;
        r_pos      <= n_pos;
        r_b        <= n_b;
        r_d        <= n_d;
        r_n        <= n_n;
        r_r        <= n_r;
        r_ent      <= n_ent;
        r_hole     <= n_hole;
        r_ci       <= n_ci;
        r_w        <= n_w;
        r_cret_ins <= n_cret_ins;
        r_status   <= n_status;
        r_fk       <= n_fk;
        r_fv       <= n_fv;
        r_np       <= n_np;
        r_out      <= n_out;
    end

    logic [BKT_W-1:0] rd;
    logic             key_match;
    logic             bk_free;
    logic [ENT_W-1:0] live_dec;

    assign rd        = r_b - r_ent_q.hash[BKT_W-1:0];
    assign key_match = (r_ent_q.hash == r_hash) && (r_ent_q.key == r_key);
    assign bk_free   = (bk_q >= ENT_SLOTS8);
    assign live_dec  = (r_live != '0) ? r_live - 8'd1 : r_live;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_op        = r_op;
        n_key       = r_key;
        n_hash      = r_hash;
        n_val       = r_val;
        n_pos       = r_pos;
        n_b         = r_b;
        n_d         = r_d;
        n_n         = r_n;
        n_r         = r_r;
        n_ent       = r_ent;
        n_hole      = r_hole;
        n_ci        = r_ci;
        n_w         = r_w;
        n_used      = r_used;
        n_live      = r_live;
        n_rebuild   = r_rebuild;
        n_cret_ins  = r_cret_ins;
        n_status    = r_status;
        n_fk        = r_fk;
        n_fv        = r_fv;
        n_np        = r_np;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        bk          = '0;
        ent_rd_en   = 1'b0;
        ent_rd_addr = '0;
        ent_we      = 1'b0;
        ent_wa      = '0;
        ent_wd      = r_ent_q;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in.op;
                    n_key   = i_in.key;
                    n_hash  = (i_in.key_digest == '1) ? '0 : i_in.key_digest;
                    n_val   = i_in.value;
                    n_pos   = i_in.position;
                    n_state = S_START;
                end
            end

            S_START: begin
                n_status = ST_MISS;
                n_fk     = '0;
                n_fv     = '0;
                n_np     = '0;
                n_b      = r_hash[BKT_W-1:0];
                n_d      = '0;
                n_n      = '0;
                n_state  = S_DONE;
                case (r_op)
                    OP_INSERT: begin
                        if (r_used >= ENT_SLOTS8 && r_live < r_used) begin
                            n_cret_ins = 1'b1;
                            n_state    = S_CMP_BEGIN;
                        end else begin
                            n_state = S_INS_CHK;
                        end
                    end
                    OP_LOOKUP, OP_REMOVE: begin
                        n_mode  = M_FIND;
                        n_state = S_PRB_RD;
                    end
                    OP_CLEAR: begin
                        bk.clr   = 1'b1;
                        n_used   = '0;
                        n_live   = '0;
                        n_status = ST_INSERTED;
                    end
                    OP_ITERATE: begin
                        n_status = ST_ITER_END;
                        n_np     = r_used;
                        n_ci     = r_pos;
                        if (r_pos <= r_used) begin
                            n_state = S_IT_RD;
                        end
                    end
                    default: begin
                        n_status = ST_MISS;
                    end
                endcase
            end

            S_INS_CHK: begin
                if (r_used >= ENT_SLOTS8) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_b     = r_hash[BKT_W-1:0];
                    n_d     = '0;
                    n_n     = '0;
                    n_mode  = M_INS;
                    n_state = S_PRB_RD;
                end
            end

            S_PRB_RD: begin
                bk.rd_en   = 1'b1;
                bk.rd_addr = r_b;
                n_state    = S_PRB_BK;
            end

            S_PRB_BK: begin
                n_r = bk_q;
                if (bk_free) begin
                    case (r_mode)
                        M_FIND: begin
                            n_status = ST_MISS;
                            n_state  = S_DONE;
                        end
                        M_INS: begin
                            bk.wr_en   = 1'b1;
                            bk.wr_addr = r_b;
                            bk.wr_data = r_used;
                            ent_we     = 1'b1;
                            ent_wa     = r_used;
                            ent_wd     = '{hole: 1'b0, hash: r_hash, key: r_key, value: r_val};
                            n_used     = r_used + 8'd1;
                            n_live     = r_live + 8'd1;
                            n_status   = ST_INSERTED;
                            n_state    = S_DONE;
                        end
                        M_PLACE: begin
                            bk.wr_en   = 1'b1;
                            bk.wr_addr = r_b;
                            bk.wr_data = r_ent;
                            if (r_rebuild) begin
                                n_state = S_RB_EN;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_REM_CHK;
                        end
                    endcase
                    if (r_mode == M_PLACE && r_rebuild) begin
                        // Move on to the next entry to place, or finish the rebuild.
                        if (r_ci + 8'd1 < r_used) begin
                            n_ci    = r_ci + 8'd1;
                            n_state = S_RB_RD;
                        end else begin
                            n_rebuild = 1'b0;
                            n_state   = r_cret_ins ? S_INS_CHK : S_DONE;
                        end
                    end
                end else begin
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = bk_q;
                    n_state     = S_PRB_EN;
                end
            end

            S_PRB_EN: begin
                n_b     = r_b + 8'd1;
                n_d     = r_d + 10'd1;
                n_n     = r_n + 9'd1;
                n_state = S_PRB_RD;
                case (r_mode)
                    M_FIND: begin
                        if (r_d > {2'b00, rd}) begin
                            n_status = ST_MISS;
                            n_state  = S_DONE;
                        end else if (key_match) begin
                            n_b      = r_b;
                            n_status = ST_HIT;
                            n_fk     = r_ent_q.key;
                            n_fv     = r_ent_q.value;
                            n_state  = S_DONE;
                            if (r_op == OP_REMOVE) begin
                                n_used = r_used;
                                if (r_r + 8'd1 == r_used) begin
                                    n_used = r_used - 8'd1;
                                end else begin
                                    ent_we      = 1'b1;
                                    ent_wa      = r_r;
                                    ent_wd.hole = 1'b1;
                                end
                                n_live = live_dec;
                                if (live_dec == '0) begin
                                    n_used = '0;
                                end
                                bk.wr_en   = 1'b1;
                                bk.wr_addr = r_b;
                                bk.wr_data = ENT_EMPTY;
                                n_hole     = r_b;
                                n_b        = r_b + 8'd1;
                                n_n        = '0;
                                n_mode     = M_UNLINK;
                                n_state    = S_PRB_RD;
                            end
                        end else if (r_n == LAST_STEP) begin
                            n_status = ST_MISS;
                            n_state  = S_DONE;
                        end
                    end
                    M_INS: begin
                        if ({2'b00, rd} < r_d) begin
                            // Steal this bucket and carry the resident entry onward.
                            bk.wr_en   = 1'b1;
                            bk.wr_addr = r_b;
                            bk.wr_data = r_used;
                            ent_we     = 1'b1;
                            ent_wa     = r_used;
                            ent_wd     = '{hole: 1'b0, hash: r_hash, key: r_key, value: r_val};
                            n_used     = r_used + 8'd1;
                            n_live     = r_live + 8'd1;
                            n_status   = ST_INSERTED;
                            n_ent      = r_r;
                            n_d        = {2'b00, rd} + 10'd1;
                            n_n        = '0;
                            n_mode     = M_PLACE;
                        end else if (key_match) begin
                            ent_we       = 1'b1;
                            ent_wa       = r_r;
                            ent_wd.value = r_val;
                            n_status     = ST_UPDATED;
                            n_state      = S_DONE;
                        end else if (r_n == LAST_STEP) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end
                    end
                    M_PLACE: begin
                        if ({2'b00, rd} < r_d) begin
                            bk.wr_en   = 1'b1;
                            bk.wr_addr = r_b;
                            bk.wr_data = r_ent;
                            n_ent      = r_r;
                            n_d        = {2'b00, rd} + 10'd1;
                        end
                        if (r_n == LAST_STEP) begin
                            if (r_rebuild) begin
                                if (r_ci + 8'd1 < r_used) begin
                                    n_ci    = r_ci + 8'd1;
                                    n_state = S_RB_RD;
                                end else begin
                                    n_rebuild = 1'b0;
                                    n_state   = r_cret_ins ? S_INS_CHK : S_DONE;
                                end
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                    end
                    default: begin
                        n_b = r_b;
                        n_d = r_d;
                        n_n = r_n;
                        if (rd == '0) begin
                            n_state = S_REM_CHK;
                        end else begin
                            bk.wr_en   = 1'b1;
                            bk.wr_addr = r_hole;
                            bk.wr_data = r_r;
                            n_state    = S_UL_CLR;
                        end
                    end
                endcase
            end

            S_UL_CLR: begin
                bk.wr_en   = 1'b1;
                bk.wr_addr = r_b;
                bk.wr_data = ENT_EMPTY;
                n_hole     = r_b;
                n_b        = r_b + 8'd1;
                n_n        = r_n + 9'd1;
                n_state    = (r_n == LAST_STEP) ? S_REM_CHK : S_PRB_RD;
            end

            S_REM_CHK: begin
                if (r_live <= {1'b0, r_used[ENT_W-1:1]}) begin
                    n_cret_ins = 1'b0;
                    n_state    = S_CMP_BEGIN;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_CMP_BEGIN: begin
                n_ci = '0;
                n_w  = '0;
                if (r_live == r_used) begin
                    n_state = r_cret_ins ? S_INS_CHK : S_DONE;
                end else begin
                    n_state = S_CMP_RD;
                end
            end

            S_CMP_RD: begin
                if (r_ci < r_used && r_ci < ENT_SLOTS8) begin
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = r_ci;
                    n_state     = S_CMP_WR;
                end else begin
                    n_state = S_CMP_CLR;
                end
            end

            S_CMP_WR: begin
                if (!r_ent_q.hole) begin
                    ent_we = 1'b1;
                    ent_wa = r_w;
                    n_w    = r_w + 8'd1;
                end
                n_ci    = r_ci + 8'd1;
                n_state = S_CMP_RD;
            end

            S_CMP_CLR: begin
                bk.clr = 1'b1;
                n_used = r_w;
                n_live = r_w;
                n_ci   = '0;
                if (r_w == '0) begin
                    n_state = r_cret_ins ? S_INS_CHK : S_DONE;
                end else begin
                    n_rebuild = 1'b1;
                    n_state   = S_RB_RD;
                end
            end

            S_RB_RD: begin
                ent_rd_en   = 1'b1;
                ent_rd_addr = r_ci;
                n_state     = S_RB_EN;
            end

            S_RB_EN: begin
                n_ent   = r_ci;
                n_b     = r_ent_q.hash[BKT_W-1:0];
                n_d     = '0;
                n_n     = '0;
                n_mode  = M_PLACE;
                n_state = S_PRB_RD;
            end

            S_IT_RD: begin
                if (r_ci < r_used && r_ci < ENT_SLOTS8) begin
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = r_ci;
                    n_state     = S_IT_EN;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_IT_EN: begin
                if (!r_ent_q.hole) begin
                    n_status = ST_HIT;
                    n_fk     = r_ent_q.key;
                    n_fv     = r_ent_q.value;
                    n_np     = r_ci + 8'd1;
                    n_state  = S_DONE;
                end else begin
                    n_ci    = r_ci + 8'd1;
                    n_state = S_IT_RD;
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status        = r_status;
                    n_out.found_key     = r_fk;
                    n_out.found_value   = r_fv;
                    n_out.next_position = r_np;
                    n_out.live_entries  = r_live;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/tb.sv =====
// Testbench for robin_hood_ordered_hash_map: directed table, then random traffic.
// Each result is checked against an in-bench model of the ordered hash map or a fixed expected value.
// Depends on rhohm_pkg and the robin_hood_ordered_hash_map RTL.
`timescale 1ns / 1ps

module tb;
    import rhohm_pkg::*;

    localparam int WATCHDOG_LIMIT = 500000;
    localparam int HOLD_CYCLES    = 600;
    localparam int RANDOM_ITEMS   = 1800;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    robin_hood_ordered_hash_map dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the map.
    logic [7:0]  bucket_ent [BUCKETS];
    logic [31:0] ent_hash [ENTRY_SLOTS];
    logic [63:0] ent_key [ENTRY_SLOTS];
    logic [63:0] ent_value [ENTRY_SLOTS];
    bit          ent_hole [ENTRY_SLOTS];
    int          used_cnt;
    int          live_cnt;

    t_out result_q[$];
    int   error_cnt = 0;
    bit   hold_req = 1'b0;
    int   idle_cycles = 0;

    function automatic int dist_at(int ent, int b);
        return (b - int'(ent_hash[ent][7:0])) & (BUCKETS - 1);
    endfunction

    function automatic bit is_free(int r);
        return r == int'(ENT_EMPTY) || r >= ENTRY_SLOTS;
    endfunction

    function automatic void place_entry(int ent, int b, int d);
        int r;
        int rd;
        for (int n = 0; n < BUCKETS; n++) begin
            r = bucket_ent[b];
            if (is_free(r)) begin
                bucket_ent[b] = 8'(ent);
                return;
            end
            rd = dist_at(r, b);
            if (rd < d) begin
                bucket_ent[b] = 8'(ent);
                ent = r;
                d = rd;
            end
            b = (b + 1) & (BUCKETS - 1);
            d++;
        end
    endfunction

    function automatic bit find_key(logic [31:0] h, logic [63:0] key,
                                    output int bkt, output int ent);
        int b;
        int r;
        b = h[7:0];
        bkt = 0;
        ent = 0;
        for (int d = 0; d < BUCKETS; d++) begin
            r = bucket_ent[b];
            if (is_free(r) || d > dist_at(r, b))
                return 1'b0;
            if (ent_hash[r] == h && ent_key[r] == key) begin
                bkt = b;
                ent = r;
                return 1'b1;
            end
            b = (b + 1) & (BUCKETS - 1);
        end
        return 1'b0;
    endfunction

    function automatic void compact_entries();
        int w;
        w = 0;
        if (live_cnt == used_cnt)
            return;
        for (int r = 0; r < used_cnt; r++) begin
            if (!ent_hole[r]) begin
                ent_hash[w]  = ent_hash[r];
                ent_key[w]   = ent_key[r];
                ent_value[w] = ent_value[r];
                ent_hole[w]  = 1'b0;
                w++;
            end
        end
        used_cnt = w;
        live_cnt = w;
        for (int b = 0; b < BUCKETS; b++)
            bucket_ent[b] = ENT_EMPTY;
        for (int r = 0; r < used_cnt; r++)
            place_entry(r, ent_hash[r][7:0], 0);
    endfunction

    // Backshift the buckets that follow a freed one.
    function automatic void unlink_bucket(int hole);
        int cur;
        int r;
        cur = (hole + 1) & (BUCKETS - 1);
        bucket_ent[hole] = ENT_EMPTY;
        for (int n = 0; n < BUCKETS; n++) begin
            r = bucket_ent[cur];
            if (is_free(r) || dist_at(r, cur) == 0)
                break;
            bucket_ent[hole] = 8'(r);
            bucket_ent[cur] = ENT_EMPTY;
            hole = cur;
            cur = (cur + 1) & (BUCKETS - 1);
        end
    endfunction

    function automatic t_out apply_op(t_in it);
        t_out res;
        logic [31:0] h;
        int b;
        int ent;
        int d;
        int r;
        int rd;
        int p;
        bit steal;
        res = '0;
        res.status = ST_MISS;
        h = (it.key_digest == 32'hFFFF_FFFF) ? 32'h0 : it.key_digest;
        case (it.op)
            OP_INSERT: begin
                if (used_cnt >= ENTRY_SLOTS && live_cnt < used_cnt)
                    compact_entries();
                res.status = ST_FULL;
                if (used_cnt < ENTRY_SLOTS) begin
                    b = h[7:0];
                    d = 0;
                    for (int n = 0; n < BUCKETS; n++) begin
                        r = bucket_ent[b];
                        steal = 1'b0;
                        rd = 0;
                        if (!is_free(r)) begin
                            rd = dist_at(r, b);
                            if (rd < d) begin
                                steal = 1'b1;
                            end else if (ent_hash[r] == h && ent_key[r] == it.key) begin
                                ent_value[r] = it.value;
                                res.status = ST_UPDATED;
                                break;
                            end
                        end
                        if (is_free(r) || steal) begin
                            bucket_ent[b] = 8'(used_cnt);
                            ent_hash[used_cnt] = h;
                            ent_key[used_cnt] = it.key;
                            ent_value[used_cnt] = it.value;
                            ent_hole[used_cnt] = 1'b0;
                            used_cnt++;
                            live_cnt++;
                            if (steal)
                                place_entry(r, (b + 1) & (BUCKETS - 1), rd + 1);
                            res.status = ST_INSERTED;
                            break;
                        end
                        b = (b + 1) & (BUCKETS - 1);
                        d++;
                    end
                end
            end
            OP_LOOKUP: begin
                if (find_key(h, it.key, b, ent)) begin
                    res.status = ST_HIT;
                    res.found_key = ent_key[ent];
                    res.found_value = ent_value[ent];
                end
            end
            OP_REMOVE: begin
                if (find_key(h, it.key, b, ent)) begin
                    res.status = ST_HIT;
                    res.found_key = ent_key[ent];
                    res.found_value = ent_value[ent];
                    if (ent + 1 == used_cnt)
                        used_cnt--;
                    else
                        ent_hole[ent] = 1'b1;
                    if (live_cnt > 0)
                        live_cnt--;
                    if (live_cnt == 0)
                        used_cnt = 0;
                    unlink_bucket(b);
                    if (live_cnt <= used_cnt / 2)
                        compact_entries();
                end
            end
            OP_CLEAR: begin
                for (int n = 0; n < BUCKETS; n++)
                    bucket_ent[n] = ENT_EMPTY;
                used_cnt = 0;
                live_cnt = 0;
                res.status = ST_INSERTED;
            end
            OP_ITERATE: begin
                res.status = ST_ITER_END;
                res.next_position = 8'(used_cnt);
                if (int'(it.position) <= used_cnt) begin
                    for (p = it.position; p < used_cnt; p++) begin
                        if (!ent_hole[p]) begin
                            res.status = ST_HIT;
                            res.found_key = ent_key[p];
                            res.found_value = ent_value[p];
                            res.next_position = 8'(p + 1);
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.live_entries = 8'(live_cnt);
        return res;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $realtime, field, got, want);
        error_cnt++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                report("unexpected item", 64'(o_out.status), 64'h0);
            end else begin
                want = result_q.pop_front();
                if (o_out.status !== want.status)
                    report("status", 64'(o_out.status), 64'(want.status));
                if (o_out.found_key !== want.found_key)
                    report("found_key", o_out.found_key, want.found_key);
                if (o_out.found_value !== want.found_value)
                    report("found_value", o_out.found_value, want.found_value);
                if (o_out.next_position !== want.next_position)
                    report("next_position", 64'(o_out.next_position),
                           64'(want.next_position));
                if (o_out.live_entries !== want.live_entries)
                    report("live_entries", 64'(o_out.live_entries),
                           64'(want.live_entries));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without progress", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int mode;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 9);
                i_out_ready <= 1'b1;
                repeat (mode == 0 ? 200 : $urandom_range(1, 8)) @(posedge i_clk);
                if (mode != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (pick_gap() + 1) @(posedge i_clk);
                end
            end
        end
    end

    // Offers one item and records its expected result when it is taken.
    task automatic send_item(t_in it, int gap, bit typed, t_out typed_res);
        t_out pred;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pred = apply_op(it);
        result_q.push_back(typed ? typed_res : pred);
    endtask

    function automatic t_in make_item(logic [2:0] op, logic [63:0] key, logic [31:0] h,
                                      logic [63:0] value, logic [7:0] pos);
        t_in it;
        it.op = op;
        it.key = key;
        it.key_digest = h;
        it.value = value;
        it.position = pos;
        return it;
    endfunction

    function automatic t_out make_res(logic [2:0] st, logic [7:0] np, logic [7:0] live);
        t_out res;
        res = '0;
        res.status = st;
        res.next_position = np;
        res.live_entries = live;
        return res;
    endfunction

    typedef struct {
        t_in  it;
        bit   typed;
        t_out res;
    } t_row;

    localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

    function automatic logic [63:0] key_of(int idx, int salt);
        logic [31:0] a;
        a = 32'(idx + salt * 997);
        return {a * 32'h9E37_79B1, ~a * 32'h85EB_CA6B};
    endfunction

    // Home buckets are squeezed into the first span buckets to force long probe chains when span is small.
    function automatic logic [31:0] hash_of(int idx, int span);
        logic [31:0] m;
        m = 32'(idx) * 32'hC2B2_AE35;
        return {m[31:8], 8'((idx * 7) % span)};
    endfunction

    initial begin
        t_row rows[$];
        t_in  it;
        t_out res;
        int   idx;
        int   pool;
        int   span;
        int   salt;
        int   w;
        int   ins_w;
        int   gap_off;
        logic [2:0]  op;
        logic [31:0] h;
        logic [7:0]  pos;

        for (int b = 0; b < BUCKETS; b++)
            bucket_ent[b] = ENT_EMPTY;
        used_cnt = 0;
        live_cnt = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back('{make_item(OP_LOOKUP, 64'h1, 32'h1, 0, 0), 1,
                         make_res(ST_MISS, 0, 0)});
        rows.push_back('{make_item(OP_ITERATE, 0, 0, 0, 0), 1,
                         make_res(ST_ITER_END, 0, 0)});
        rows.push_back('{make_item(OP_REMOVE, 64'h5, 32'h5, 0, 0), 1,
                         make_res(ST_MISS, 0, 0)});
        rows.push_back('{make_item(3'd5, ONES64, 32'h7, ONES64, 8'hFF), 1,
                         make_res(ST_MISS, 0, 0)});
        rows.push_back('{make_item(3'd6, 0, 0, 0, 0), 1, make_res(ST_MISS, 0, 0)});
        rows.push_back('{make_item(3'd7, 0, 0, 0, 0), 1, make_res(ST_MISS, 0, 0)});
        rows.push_back('{make_item(OP_INSERT, 0, 0, 0, 0), 1,
                         make_res(ST_INSERTED, 0, 1)});
        // An all-ones hash folds to zero and so shares the first key's home.
        rows.push_back('{make_item(OP_INSERT, ONES64, 32'hFFFF_FFFF, ONES64, 0), 1,
                         make_res(ST_INSERTED, 0, 2)});
        rows.push_back('{make_item(OP_LOOKUP, ONES64, 32'h0, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_INSERT, 0, 0, ONES64, 0), 1,
                         make_res(ST_UPDATED, 0, 2)});
        rows.push_back('{make_item(OP_LOOKUP, 0, 32'hFFFF_FFFF, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_ITERATE, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_ITERATE, 0, 0, 0, 8'd1), 0, '0});
        rows.push_back('{make_item(OP_ITERATE, 0, 0, 0, 8'hFF), 1,
                         make_res(ST_ITER_END, 8'd2, 8'd2)});
        rows.push_back('{make_item(OP_INSERT, 64'h11, 32'hAB05, 64'h111, 0), 0, '0});
        rows.push_back('{make_item(OP_INSERT, 64'h22, 32'hCD05, 64'h222, 0), 0, '0});
        rows.push_back('{make_item(OP_INSERT, 64'h33, 32'h0006, 64'h333, 0), 0, '0});
        rows.push_back('{make_item(OP_INSERT, 64'h44, 32'h0004, 64'h444, 0), 0, '0});
        rows.push_back('{make_item(OP_LOOKUP, 64'h33, 32'h0006, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_REMOVE, 64'h44, 32'h0004, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_REMOVE, 64'h11, 32'hAB05, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_LOOKUP, 64'h22, 32'hCD05, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_ITERATE, 0, 0, 0, 8'd2), 0, '0});
        rows.push_back('{make_item(OP_CLEAR, 0, 0, 0, 0), 1,
                         make_res(ST_INSERTED, 0, 0)});
        rows.push_back('{make_item(OP_ITERATE, 0, 0, 0, 8'd0), 1,
                         make_res(ST_ITER_END, 0, 0)});

        foreach (rows[i])
            send_item(rows[i].it, pick_gap(), rows[i].typed, rows[i].res);

        // Random traffic in segments; each segment picks a key pool size, a hash
        // spread and an insert weight, so some segments fill the array to full.
        pool = 16;
        span = 16;
        ins_w = 40;
        salt = 0;
        gap_off = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0: begin pool = 12;  span = 4;   ins_w = 40; end
                    1: begin pool = 64;  span = 32;  ins_w = 45; end
                    2: begin pool = 240; span = 256; ins_w = 80; end
                    default: begin pool = 240; span = 20; ins_w = 60; end
                endcase
                salt = $urandom_range(0, 7);
                gap_off = ($urandom_range(0, 3) == 0);
            end
            if (n == 600)
                hold_req = 1'b1;
            if (n == 1200) begin
                i_in_valid <= 1'b0;
                while (result_q.size() != 0) @(posedge i_clk);
            end
            idx = $urandom_range(0, pool - 1);
            w = $urandom_range(0, 99);
            if (w < ins_w)
                op = OP_INSERT;
            else if (w < ins_w + (100 - ins_w) * 4 / 10)
                op = OP_LOOKUP;
            else if (w < ins_w + (100 - ins_w) * 8 / 10)
                op = OP_REMOVE;
            else if (w < 98)
                op = OP_ITERATE;
            else if (w == 98)
                op = OP_CLEAR;
            else
                op = 3'($urandom_range(5, 7));
            h = hash_of(idx, span);
            case ($urandom_range(0, 39))
                0: h = $urandom;
                1: h = 32'hFFFF_FFFF;
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                pos = 8'($urandom_range(0, 255));
            else
                pos = 8'($urandom_range(0, used_cnt + 1));
            it = make_item(op, key_of(idx, salt), h, {$urandom, $urandom}, pos);
            send_item(it, gap_off ? 0 : pick_gap(), 1'b0, res);
        end
        i_in_valid <= 1'b0;

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rhohm_pkg.sv
hw/rtl/rhohm_bucket_index.sv
hw/rtl/robin_hood_ordered_hash_map.sv
tb/tb.sv
